// ===== rtl/trie_pkg.sv =====
`default_nettype none
package trie_pkg;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_LOOKUP = 2'd1;
	localparam logic [1:0] ACT_PREFIX = 2'd2;

	localparam int LETTER_W = 5;
	localparam int ACT_W    = 2;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 8;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic accept;
		logic exec;
		logic cnt_rd;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic word_end;
	} stat_t;

endpackage
`default_nettype wire

// ===== rtl/trie_dp.sv =====
`default_nettype none
module trie_dp #(
	parameter int NODE_COUNT    = 4096,
	parameter int ALPHABET_SIZE = 26,
	parameter int COUNT_BITS    = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire trie_pkg::cmd_t                    cmd,
	output trie_pkg::stat_t                        stat,
	input  wire logic [trie_pkg::ACT_W-1:0]        action,
	input  wire logic [trie_pkg::LETTER_W-1:0]     letter,
	input  wire logic                              word_end,
	output logic                                   found,
	output logic                                   status
);

	localparam int NW    = $clog2(NODE_COUNT);
	localparam int UW    = $clog2(NODE_COUNT + 1);
	localparam int DEPTH = NODE_COUNT * ALPHABET_SIZE;
	localparam int SW    = $clog2(DEPTH);
	localparam int LW    = trie_pkg::LETTER_W;

	logic [NW-1:0]         link_mem [DEPTH];
	logic [COUNT_BITS-1:0] cnt_mem  [NODE_COUNT];

	logic [trie_pkg::ACT_W-1:0] act_q;
	logic [LW-1:0]         letter_q;
	logic                  end_q;
	logic [SW-1:0]         addr_q;
	logic [NW-1:0]         rd_link_q;
	logic [COUNT_BITS-1:0] rd_cnt_q;
	logic                  found_q;
	logic                  status_q;

	logic [NW-1:0]         cursor_q;
	logic [SW-1:0]         base_q;
	logic [UW-1:0]         used_q;
	logic                  settled_q;
	logic                  answer_q;
	logic                  ovf_q;
	logic [SW-1:0]         clr_q;

	logic [SW+LW-1:0]      slot_sum;
	logic [SW-1:0]         slot_addr;
	logic                  settle;
	logic                  settle_val;
	logic                  ovf_set;
	logic                  alloc;
	logic                  adv;
	logic [NW-1:0]         nxt;
	logic [SW-1:0]         nxt_base;
	logic                  link_we;
	logic [SW-1:0]         link_wa;
	logic [NW-1:0]         link_wd;
	logic                  cnt_we;
	logic [NW-1:0]         cnt_wa;
	logic [COUNT_BITS-1:0] cnt_wd;
	logic                  cnt_bump;
	logic                  found_d;

	assign slot_sum  = (SW+LW)'(base_q) + (SW+LW)'(letter);
	assign slot_addr = slot_sum[SW-1:0];

	// one step of the walk, from the registered table reads
	always_comb begin
		settle     = 1'b0;
		settle_val = 1'b0;
		ovf_set    = 1'b0;
		alloc      = 1'b0;
		adv        = 1'b0;
		nxt        = rd_link_q;
		if (!settled_q) begin
			if (act_q == trie_pkg::ACT_PREFIX && rd_cnt_q != '0) begin
				settle     = 1'b1;
				settle_val = 1'b1;
			end else if (32'(letter_q) >= ALPHABET_SIZE) begin
				settle = 1'b1;
			end else if (rd_link_q == '0) begin
				if (act_q != trie_pkg::ACT_INSERT) begin
					settle = 1'b1;
				end else if (used_q == UW'(NODE_COUNT)) begin
					settle  = 1'b1;
					ovf_set = 1'b1;
				end else begin
					alloc = 1'b1;
					adv   = 1'b1;
					nxt   = used_q[NW-1:0];
				end
			end else begin
				adv = 1'b1;
			end
		end
	end

	assign nxt_base = SW'(nxt) * SW'(ALPHABET_SIZE);

	assign cnt_bump = act_q == trie_pkg::ACT_INSERT && !settled_q && rd_cnt_q != '1;

	always_comb begin
		if (act_q == trie_pkg::ACT_INSERT) begin
			found_d = 1'b0;
		end else if (settled_q) begin
			found_d = answer_q;
		end else begin
			found_d = rd_cnt_q != '0;
		end
	end

	// single write port on each table
	assign link_we = cmd.clear || (cmd.exec && alloc);
	assign link_wa = cmd.clear ? clr_q : addr_q;
	assign link_wd = cmd.clear ? '0 : used_q[NW-1:0];

	assign cnt_we = (cmd.clear && clr_q < SW'(NODE_COUNT)) || (cmd.finish && cnt_bump);
	assign cnt_wa = cmd.clear ? clr_q[NW-1:0] : cursor_q;
	assign cnt_wd = cmd.clear ? '0 : rd_cnt_q + COUNT_BITS'(1);

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		if (cmd.accept) begin
			rd_link_q <= link_mem[slot_addr];
		end
		if (cmd.accept || cmd.cnt_rd) begin
			rd_cnt_q <= cnt_mem[cursor_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q    <= action;
			letter_q <= letter;
			end_q    <= word_end;
			addr_q   <= slot_addr;
		end
		if (cmd.finish) begin
			found_q  <= found_d;
			status_q <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q  <= '0;
			base_q    <= '0;
			used_q    <= UW'(1);
			settled_q <= 1'b0;
			answer_q  <= 1'b0;
			ovf_q     <= 1'b0;
			clr_q     <= '0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + SW'(1);
			end
			if (cmd.exec) begin
				if (settle) begin
					settled_q <= 1'b1;
					answer_q  <= settle_val;
				end
				if (ovf_set) begin
					ovf_q <= 1'b1;
				end
				if (alloc) begin
					used_q <= used_q + UW'(1);
				end
				if (adv) begin
					cursor_q <= nxt;
					base_q   <= nxt_base;
				end
			end
			if (cmd.finish) begin
				cursor_q  <= '0;
				base_q    <= '0;
				settled_q <= 1'b0;
				answer_q  <= 1'b0;
				ovf_q     <= 1'b0;
			end
		end
	end

	assign stat.clr_last = clr_q == SW'(DEPTH - 1);
	assign stat.word_end = end_q;
	assign found  = found_q;
	assign status = status_q;

endmodule
`default_nettype wire

// ===== rtl/trie_ctrl.sv =====
`default_nettype none
module trie_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire trie_pkg::stat_t stat,
	output trie_pkg::cmd_t       cmd,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_EXEC  = 3'd2;
	localparam logic [2:0] ST_CNTRD = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = stat.word_end ? ST_CNTRD : ST_IDLE;
			end
			ST_CNTRD: begin
				cmd.cnt_rd = 1'b1;
				state_d    = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== rtl/trie_insert_lookup_prefix.sv =====
`default_nettype none
// channel  dir  handshake          payload
// s        in   s_tvalid/s_tready  s_tdata[4:0] letter, s_tuser[1:0] action, s_tlast word_end
// m        out  m_tvalid/m_tready  m_tdata[0] found, m_tdata[1] status
//
// a letter that is not the last is handled as a table read, then a walk step and link write
// the last letter then reads the end node count and, on an insert, writes it back
// after reset a clearing pass zeroes the tables
// while the pass runs s_tready stays low
// a held result on m does not block input until the next word end needs the output register
module trie_insert_lookup_prefix #(
	parameter int NODE_COUNT    = 4096,
	parameter int ALPHABET_SIZE = 26,
	parameter int COUNT_BITS    = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [trie_pkg::IN_DATA_W-1:0]     s_tdata,  // letter[4:0]
	input  wire logic [trie_pkg::ACT_W-1:0]         s_tuser,  // action[1:0]
	input  wire logic                               s_tlast,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [trie_pkg::OUT_DATA_W-1:0]         m_tdata   // found, status
);

	trie_pkg::cmd_t  cmd;
	trie_pkg::stat_t stat;
	logic            found;
	logic            status;

	trie_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.stat      (stat),
		.cmd       (cmd),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready)
	);

	trie_dp #(
		.NODE_COUNT    (NODE_COUNT),
		.ALPHABET_SIZE (ALPHABET_SIZE),
		.COUNT_BITS    (COUNT_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.action   (s_tuser),
		.letter   (s_tdata[trie_pkg::LETTER_W-1:0]),
		.word_end (s_tlast),
		.found    (found),
		.status   (status)
	);

	assign m_tdata = {(trie_pkg::OUT_DATA_W-2)'(0), status, found};

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

	localparam int NODES        = 4096;
	localparam int ALPHA        = 26;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;
	localparam logic [1:0] ACT_UNDEF  = 2'd3;
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int DRAIN_CYCLES = 12;
	localparam int RANDOM_ITEMS = 1350;

	typedef struct packed {
		logic found;
		logic status;
	} answer_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [trie_pkg::IN_DATA_W-1:0]  s_tdata;   // letter[4:0], zero fill
	logic [trie_pkg::ACT_W-1:0]      s_tuser;   // action[1:0]
	logic                            s_tlast;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [trie_pkg::OUT_DATA_W-1:0] m_tdata;   // found, status, zero fill

	// trie mirror
	logic [11:0] link_tbl [NODES*ALPHA];
	logic [15:0] count_tbl [NODES];
	int unsigned nodes_taken;
	logic [11:0] walk_node;
	logic        walk_stopped;
	logic        walk_answer;
	logic        walk_pool_full;

	answer_t answers_due[$];
	int      mismatch_count = 0;
	int      cycle_count = 0;
	bit      tx_gaps;
	bit      rx_random;
	int      rx_hold_req;

	trie_insert_lookup_prefix dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic flag_mismatch(input string msg);
		if (mismatch_count < 50)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	function automatic void clear_trie();
		foreach (link_tbl[i])
			link_tbl[i] = '0;
		foreach (count_tbl[i])
			count_tbl[i] = '0;
		nodes_taken = 1;
		walk_node = '0;
		walk_stopped = 1'b0;
		walk_answer = 1'b0;
		walk_pool_full = 1'b0;
	endfunction

	// advance the mirror by one letter, queue the answer on the word end
	function automatic void trie_walk_letter(input logic [1:0] act, input logic [4:0] ltr,
			input logic last);
		int      idx;
		logic [11:0] nxt;
		answer_t ans;
		if (!walk_stopped) begin
			if (act == trie_pkg::ACT_PREFIX && count_tbl[walk_node] != 0) begin
				walk_stopped = 1'b1;
				walk_answer = 1'b1;
			end else if (ltr >= ALPHA) begin
				walk_stopped = 1'b1;
				walk_answer = 1'b0;
			end else begin
				idx = int'(walk_node) * ALPHA + int'(ltr);
				nxt = link_tbl[idx];
				if (nxt != 0) begin
					walk_node = nxt;
				end else if (act != trie_pkg::ACT_INSERT) begin
					walk_stopped = 1'b1;
					walk_answer = 1'b0;
				end else if (nodes_taken >= NODES) begin
					walk_pool_full = 1'b1;
					walk_stopped = 1'b1;
					walk_answer = 1'b0;
				end else begin
					link_tbl[idx] = 12'(nodes_taken);
					walk_node = 12'(nodes_taken);
					nodes_taken++;
				end
			end
		end
		if (last) begin
			ans.found = 1'b0;
			ans.status = walk_pool_full;
			if (act == trie_pkg::ACT_INSERT) begin
				if (!walk_stopped && count_tbl[walk_node] != COUNT_MAX)
					count_tbl[walk_node]++;
			end else if (walk_stopped) begin
				ans.found = walk_answer;
			end else begin
				ans.found = (count_tbl[walk_node] != 0);
			end
			answers_due.insert(answers_due.size(), ans);
			walk_node = '0;
			walk_stopped = 1'b0;
			walk_answer = 1'b0;
			walk_pool_full = 1'b0;
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		if (r < 95)
			return $urandom_range(3, 6);
		return $urandom_range(15, 50);
	endfunction

	function automatic logic [4:0] pick_letter(input bit wide);
		int r;
		r = $urandom_range(0, 99);
		if (wide)
			return 5'($urandom_range(0, ALPHA - 1));
		if (r < 70)
			return 5'($urandom_range(0, 3));
		if (r < 98)
			return 5'($urandom_range(0, ALPHA - 1));
		return 5'($urandom_range(ALPHA, 31));
	endfunction

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_letter(input logic [1:0] act, input logic [4:0] ltr, input logic last);
		int gap;
		gap = 0;
		if (tx_gaps && $urandom_range(0, 1) == 1)
			gap = pick_gap();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata = {{(trie_pkg::IN_DATA_W - trie_pkg::LETTER_W){1'b0}}, ltr};
		s_tuser = act;
		s_tlast = last;
		s_tvalid = 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		trie_walk_letter(act, ltr, last);
		@(negedge clk);
	endtask

	task automatic send_word(input logic [1:0] act, input int len, input bit mixed,
			input bit wide);
		logic [1:0] a;
		for (int i = 0; i < len; i++) begin
			a = mixed ? 2'($urandom_range(0, 3)) : act;
			send_letter(a, pick_letter(wide), i == len - 1);
		end
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// sink side
	initial begin
		int hold;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req > 0) begin
				hold = rx_hold_req;
				rx_hold_req = 0;
				m_tready = 1'b0;
				repeat (hold) @(negedge clk);
			end else if (rx_random && $urandom_range(0, 3) == 0) begin
				m_tready = 1'b0;
				repeat (pick_gap()) @(negedge clk);
			end
			m_tready = 1'b1;
		end
	end

	always @(posedge clk) begin
		answer_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (answers_due.size() == 0) begin
				flag_mismatch("result transfer with nothing expected");
			end else begin
				want = answers_due.pop_front();
				if (m_tdata[0] !== want.found)
					flag_mismatch($sformatf("found %b, expected %b", m_tdata[0], want.found));
				if (m_tdata[1] !== want.status)
					flag_mismatch($sformatf("status %b, expected %b", m_tdata[1], want.status));
			end
		end
	end

	task automatic test_directed();
		tx_gaps = 1'b0;
		rx_random = 1'b0;
		send_letter(trie_pkg::ACT_LOOKUP, 5'd0, 1'b1);
		send_letter(trie_pkg::ACT_PREFIX, 5'd25, 1'b1);
		send_letter(trie_pkg::ACT_INSERT, 5'd0, 1'b0);
		send_letter(trie_pkg::ACT_INSERT, 5'd1, 1'b1);
		send_letter(trie_pkg::ACT_LOOKUP, 5'd0, 1'b0);
		send_letter(trie_pkg::ACT_LOOKUP, 5'd1, 1'b1);
		send_letter(trie_pkg::ACT_LOOKUP, 5'd0, 1'b1);
		send_letter(trie_pkg::ACT_PREFIX, 5'd0, 1'b0);
		send_letter(trie_pkg::ACT_PREFIX, 5'd1, 1'b0);
		send_letter(trie_pkg::ACT_PREFIX, 5'd25, 1'b1);
		send_letter(trie_pkg::ACT_PREFIX, 5'd0, 1'b1);
		send_letter(trie_pkg::ACT_INSERT, 5'd25, 1'b1);
		// out of range letter drops the insert
		send_letter(trie_pkg::ACT_INSERT, 5'd25, 1'b0);
		send_letter(trie_pkg::ACT_INSERT, 5'd31, 1'b1);
		send_letter(trie_pkg::ACT_LOOKUP, 5'd31, 1'b0);
		send_letter(trie_pkg::ACT_LOOKUP, 5'd0, 1'b1);
		send_letter(trie_pkg::ACT_PREFIX, 5'd0, 1'b0);
		send_letter(trie_pkg::ACT_PREFIX, 5'd1, 1'b0);
		send_letter(trie_pkg::ACT_PREFIX, 5'd30, 1'b1);
		send_letter(ACT_UNDEF, 5'd0, 1'b0);
		send_letter(ACT_UNDEF, 5'd1, 1'b1);
		// mixed actions within one word
		send_letter(trie_pkg::ACT_PREFIX, 5'd0, 1'b0);
		send_letter(trie_pkg::ACT_INSERT, 5'd2, 1'b1);
		send_letter(trie_pkg::ACT_LOOKUP, 5'd26, 1'b1);
		send_letter(trie_pkg::ACT_LOOKUP, 5'd25, 1'b1);
		drain();
	endtask

	task automatic test_random_words();
		int sent;
		int len;
		int r;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 39) == 0) begin
				tx_gaps = 1'($urandom_range(0, 1));
				rx_random = 1'($urandom_range(0, 1));
			end
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
			r = $urandom_range(0, 99);
			if (r < 40)
				send_word(trie_pkg::ACT_INSERT, len, 1'b0, 1'b0);
			else if (r < 65)
				send_word(trie_pkg::ACT_LOOKUP, len, 1'b0, 1'b0);
			else if (r < 90)
				send_word(trie_pkg::ACT_PREFIX, len, 1'b0, 1'b0);
			else if (r < 94)
				send_word(ACT_UNDEF, len, 1'b0, 1'b0);
			else
				send_word(trie_pkg::ACT_INSERT, len, 1'b1, 1'b0);
			sent += len;
		end
		drain();
	endtask

	task automatic test_backpressure();
		tx_gaps = 1'b0;
		rx_random = 1'b0;
		rx_hold_req = 400;
		for (int i = 0; i < 20; i++)
			send_word(2'($urandom_range(0, 2)), $urandom_range(1, 3), 1'b0, 1'b0);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		s_tlast = 1'b0;
		tx_gaps = 1'b0;
		rx_random = 1'b0;
		rx_hold_req = 0;
		clear_trie();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random_words();
		test_backpressure();
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
